// ===== src/hslrgb_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hslrgb_pkg
// Shared types, constants and helpers for the HSL to RGB565 converter.
// ----------------------------------------------------------------------------
package hslrgb_pkg;

    localparam int PCT_W = 7;
    localparam int HUE_W = 16;
    localparam int NUM_W = 14;
    localparam int PIX_W = 16;

    localparam logic [PCT_W-1:0] PCT_FULL = 7'd100;
    localparam logic [8:0]       HUE_WRAP = 9'd360;
    localparam logic [8:0]       SPAN_DEG = 9'd120;
    localparam logic [NUM_W-1:0] RB_MAX   = 14'd31;
    localparam logic [NUM_W-1:0] G_MAX    = 14'd63;

    // floor(x / 360) = (x * HUE_RECIP) >> HUE_SHIFT for 16-bit x
    localparam logic [13:0] HUE_RECIP = 14'd11651;
    localparam int          HUE_SHIFT = 22;
    // floor(x / 100) = (x * PCT_RECIP) >> PCT_SHIFT for 14-bit x
    localparam logic [12:0] PCT_RECIP = 13'd5243;
    localparam int          PCT_SHIFT = 19;
    // floor(x / 3) = (x * THIRD_RECIP) >> THIRD_SHIFT for x <= 595
    localparam logic [9:0]  THIRD_RECIP = 10'd683;
    localparam int          THIRD_SHIFT = 11;

    // 60-degree sectors
    localparam logic [2:0] SECT_RY = 3'd0;
    localparam logic [2:0] SECT_YG = 3'd1;
    localparam logic [2:0] SECT_GC = 3'd2;
    localparam logic [2:0] SECT_CB = 3'd3;
    localparam logic [2:0] SECT_BM = 3'd4;
    localparam logic [2:0] SECT_MR = 3'd5;

    typedef struct packed {
        logic [2:0]       sector;
        logic [PCT_W-1:0] chroma;
        logic [PCT_W-1:0] fold;
        logic [PCT_W-1:0] light;
    } mid_t;

    function automatic logic [PCT_W-1:0] pct_div(input logic [NUM_W-1:0] x);
        logic [26:0] p;
        p = 27'(x) * 27'(PCT_RECIP);
        return p[PCT_SHIFT+PCT_W-1:PCT_SHIFT];
    endfunction

endpackage

// ===== src/hsl_to_rgb565_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsl_to_rgb565_top
// HSL colour to packed RGB565 pixel converter, integer percent arithmetic.
// ----------------------------------------------------------------------------
// Six-stage pipeline: one colour is accepted per clock unless back-pressure
// from the output side stalls it. Each stage has its own valid bit and a
// ready chain, so back-pressure holds data in place and empty stages still
// fill while the output waits. The stages follow the chain hue wrap ->
// chroma -> secondary weight -> product -> offset -> scale.
// Saturation and lightness above 100 are treated as 100.
module hsl_to_rgb565_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // hue_degrees[15:0], saturation_pct[22:16],
                                   // lightness_pct[29:23], zero[31:30]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata    // pixel_rgb565[15:0]
);
    import hslrgb_pkg::*;

    logic mid_valid, mid_ready;
    mid_t mid;

    hslrgb_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_hue    (s_tdata[15:0]),
        .in_sat    (s_tdata[22:16]),
        .in_light  (s_tdata[29:23]),
        .out_valid (mid_valid),
        .out_ready (mid_ready),
        .out_mid   (mid)
    );

    hslrgb_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (mid_valid),
        .in_ready  (mid_ready),
        .in_mid    (mid),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_pixel (m_tdata)
    );

endmodule

// ===== src/hslrgb_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hslrgb_front
// Stages 1-3: hue wrap, clamping, sector, chroma and folded secondary weight.
// ----------------------------------------------------------------------------
module hslrgb_front (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [hslrgb_pkg::HUE_W-1:0]  in_hue,
    input  logic [hslrgb_pkg::PCT_W-1:0]  in_sat,
    input  logic [hslrgb_pkg::PCT_W-1:0]  in_light,
    output logic                          out_valid,
    input  logic                          out_ready,
    output hslrgb_pkg::mid_t              out_mid
);
    import hslrgb_pkg::*;

    logic en1, en2, en3;

    // stage 1
    logic             v1_reg;
    logic [HUE_W-1:0] hue1_reg;
    logic [7:0]       q1_reg;
    logic [PCT_W-1:0] sat1_reg, light1_reg;
    logic [29:0]      qprod;

    // stage 2
    logic             v2_reg;
    logic [8:0]       h2_reg;
    logic [NUM_W-1:0] cn2_reg;
    logic [PCT_W-1:0] light2_reg;
    logic [15:0]      qx;
    logic [15:0]      hdiff;
    logic [7:0]       twol, lum_dev;
    logic [PCT_W-1:0] span;
    logic [NUM_W-1:0] cn2_next;

    // stage 3
    logic             v3_reg;
    mid_t             mid3_reg;
    mid_t             mid3_next;
    logic [8:0]       hm;
    logic [9:0]       x5;
    logic [19:0]      tprod;
    logic [7:0]       sec10, dev;

    assign en3      = !v3_reg || out_ready;
    assign en2      = !v2_reg || en3;
    assign en1      = !v1_reg || en2;
    assign in_ready = en1;

    assign qprod = 30'(in_hue) * 30'(HUE_RECIP);

    assign qx      = 16'(q1_reg) * 16'(HUE_WRAP);
    assign hdiff   = hue1_reg - qx;
    assign twol    = {light1_reg, 1'b0};
    assign lum_dev = (twol >= 8'(PCT_FULL)) ? twol - 8'(PCT_FULL) : 8'(PCT_FULL) - twol;
    assign span    = PCT_FULL - lum_dev[PCT_W-1:0];
    assign cn2_next = 14'(span) * 14'(sat1_reg);

    always_comb begin
        if (h2_reg >= 9'(2 * SPAN_DEG)) begin
            hm = h2_reg - 9'(2 * SPAN_DEG);
        end else if (h2_reg >= SPAN_DEG) begin
            hm = h2_reg - SPAN_DEG;
        end else begin
            hm = h2_reg;
        end
        if (h2_reg < 9'd60) begin
            mid3_next.sector = SECT_RY;
        end else if (h2_reg < 9'd120) begin
            mid3_next.sector = SECT_YG;
        end else if (h2_reg < 9'd180) begin
            mid3_next.sector = SECT_GC;
        end else if (h2_reg < 9'd240) begin
            mid3_next.sector = SECT_CB;
        end else if (h2_reg < 9'd300) begin
            mid3_next.sector = SECT_BM;
        end else begin
            mid3_next.sector = SECT_MR;
        end
        x5    = 10'(hm) * 10'd5;
        tprod = 20'(x5) * 20'(THIRD_RECIP);
        sec10 = tprod[THIRD_SHIFT+7:THIRD_SHIFT];
        dev   = (sec10 >= 8'(PCT_FULL)) ? sec10 - 8'(PCT_FULL) : 8'(PCT_FULL) - sec10;
        mid3_next.fold   = PCT_FULL - dev[PCT_W-1:0];
        mid3_next.chroma = pct_div(cn2_reg);
        mid3_next.light  = light2_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else begin
            if (en1) begin
                v1_reg <= in_valid;
            end
            if (en2) begin
                v2_reg <= v1_reg;
            end
            if (en3) begin
                v3_reg <= v2_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en1 && in_valid) begin
            hue1_reg   <= in_hue;
            q1_reg     <= qprod[HUE_SHIFT+7:HUE_SHIFT];
            sat1_reg   <= (in_sat > PCT_FULL) ? PCT_FULL : in_sat;
            light1_reg <= (in_light > PCT_FULL) ? PCT_FULL : in_light;
        end
        if (en2 && v1_reg) begin
            h2_reg     <= hdiff[8:0];
            cn2_reg    <= cn2_next;
            light2_reg <= light1_reg;
        end
        if (en3 && v2_reg) begin
            mid3_reg <= mid3_next;
        end
    end

    assign out_valid = v3_reg;
    assign out_mid   = mid3_reg;

endmodule

// ===== src/hslrgb_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hslrgb_back
// Stages 4-6: secondary component, channel order, offset, 5/6/5 scaling.
// ----------------------------------------------------------------------------
module hslrgb_back (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  hslrgb_pkg::mid_t              in_mid,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [hslrgb_pkg::PIX_W-1:0]  out_pixel
);
    import hslrgb_pkg::*;

    logic en4, en5, en6;

    logic             v4_reg;
    logic [NUM_W-1:0] sn4_reg;
    logic [PCT_W-1:0] chroma4_reg, m4_reg;
    logic [2:0]       sector4_reg;

    logic             v5_reg;
    logic [PCT_W-1:0] r5_reg, g5_reg, b5_reg;
    logic [PCT_W-1:0] sec, c, r5_next, g5_next, b5_next;

    logic             v6_reg;
    logic [PIX_W-1:0] pix6_reg;
    logic [PCT_W-1:0] rs, gs, bs;

    assign en6      = !v6_reg || out_ready;
    assign en5      = !v5_reg || en6;
    assign en4      = !v4_reg || en5;
    assign in_ready = en4;

    always_comb begin
        sec = pct_div(sn4_reg);
        c   = chroma4_reg;
        case (sector4_reg)
            SECT_RY: begin r5_next = c;      g5_next = sec;    b5_next = '0;  end
            SECT_YG: begin r5_next = sec;    g5_next = c;      b5_next = '0;  end
            SECT_GC: begin r5_next = '0;     g5_next = c;      b5_next = sec; end
            SECT_CB: begin r5_next = '0;     g5_next = sec;    b5_next = c;   end
            SECT_BM: begin r5_next = sec;    g5_next = '0;     b5_next = c;   end
            default: begin r5_next = c;      g5_next = '0;     b5_next = sec; end
        endcase
        r5_next = r5_next + m4_reg;
        g5_next = g5_next + m4_reg;
        b5_next = b5_next + m4_reg;
    end

    assign rs = pct_div(14'(r5_reg) * RB_MAX);
    assign gs = pct_div(14'(g5_reg) * G_MAX);
    assign bs = pct_div(14'(b5_reg) * RB_MAX);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
        end else begin
            if (en4) begin
                v4_reg <= in_valid;
            end
            if (en5) begin
                v5_reg <= v4_reg;
            end
            if (en6) begin
                v6_reg <= v5_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en4 && in_valid) begin
            sn4_reg     <= 14'(in_mid.chroma) * 14'(in_mid.fold);
            chroma4_reg <= in_mid.chroma;
            m4_reg      <= in_mid.light - (in_mid.chroma >> 1);
            sector4_reg <= in_mid.sector;
        end
        if (en5 && v4_reg) begin
            r5_reg <= r5_next;
            g5_reg <= g5_next;
            b5_reg <= b5_next;
        end
        if (en6 && v5_reg) begin
            pix6_reg <= {rs[4:0], gs[5:0], bs[4:0]};
        end
    end

    assign out_valid = v6_reg;
    assign out_pixel = pix6_reg;

endmodule

// ===== src/hslrgb_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hslrgb_checker
// Port-level checks for the HSL to RGB565 converter.
// ----------------------------------------------------------------------------
module hslrgb_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata
);

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("output valid right after reset");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled output transfer changed");

    a_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && m_tready ##1 m_tready ##1 m_tready ##1 m_tready
        ##1 m_tready ##1 m_tready |=> m_tvalid)
        else $error("accepted transfer did not reach output in six cycles");

    a_ready_flow: assert property (@(posedge aclk) disable iff (!aresetn)
        (!m_tvalid || m_tready) |-> s_tready)
        else $error("input held off while output side can move");

endmodule

bind hsl_to_rgb565_top hslrgb_checker u_hslrgb_checker (.*);

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Testbench for hsl_to_rgb565_top. Colours are sent over the input stream,
// first a directed set (sector edges, hue wrap, percent extremes and values
// above 100), then random colours. Every accepted colour is converted by an
// in-bench integer model and queued. Each pixel transfer is checked in order
// against that queue. Both sides idle at random, apart from one burst with
// no idling at all.
// ----------------------------------------------------------------------------
module tb_top;
    import hslrgb_pkg::*;

    localparam int RANDOM_COLOURS = 1625;
    localparam int STALL_LIMIT    = 4000;

    // in-order store of pixels predicted for accepted colours
    class pixel_scoreboard;
        logic [15:0] pending_pixels[$];
        int          fail_count;

        function new();
            fail_count = 0;
        endfunction

        static function logic [15:0] rgb565_of(logic [15:0] hue, logic [6:0] sat,
                                               logic [6:0] light);
            int h, s, l, chroma, sec, m, r, g, b;
            logic [2:0] sector;
            h = int'(hue) % 360;
            s = (sat > 7'd100) ? 100 : int'(sat);
            l = (light > 7'd100) ? 100 : int'(light);
            chroma = ((100 - ((2 * l - 100) < 0 ? 100 - 2 * l : 2 * l - 100)) * s) / 100;
            sec = ((h % 120) * 10) / 6;
            sec = (sec < 100) ? 100 - sec : sec - 100;
            sec = (chroma * (100 - sec)) / 100;
            sector = 3'(h / 60);
            case (sector)
                SECT_RY: begin r = chroma; g = sec;    b = 0;      end
                SECT_YG: begin r = sec;    g = chroma; b = 0;      end
                SECT_GC: begin r = 0;      g = chroma; b = sec;    end
                SECT_CB: begin r = 0;      g = sec;    b = chroma; end
                SECT_BM: begin r = sec;    g = 0;      b = chroma; end
                default: begin r = chroma; g = 0;      b = sec;    end
            endcase
            m = l - chroma / 2;
            r = ((r + m) * 31) / 100;
            g = ((g + m) * 63) / 100;
            b = ((b + m) * 31) / 100;
            return {r[4:0], g[5:0], b[4:0]};
        endfunction

        function void note_colour(logic [31:0] word);
            pending_pixels.push_back(rgb565_of(word[15:0], word[22:16], word[29:23]));
        endfunction

        function void check_pixel(logic [15:0] got);
            logic [15:0] want;
            if (pending_pixels.size() == 0) begin
                $display("%0t: unexpected pixel, expected none, actual %h", $time, got);
                fail_count++;
            end else begin
                want = pending_pixels.pop_front();
                if (got !== want) begin
                    $display("%0t: pixel mismatch, expected %h, actual %h", $time, want, got);
                    fail_count++;
                end
            end
        endfunction
    endclass

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;

    bit              no_idle = 1'b0;
    int              stall_cycles = 0;
    pixel_scoreboard pixel_sb = new();

    hsl_to_rgb565_top u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #4 aclk = ~aclk;

    // output side back-pressure
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            m_tready <= no_idle || ($urandom_range(99) >= 22);
        end
    end

    // transfer monitor and stall watchdog
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready)
                pixel_sb.note_colour(s_tdata);
            if (m_tvalid && m_tready)
                pixel_sb.check_pixel(m_tdata);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
                stall_cycles = 0;
            end else begin
                stall_cycles++;
                if (stall_cycles >= STALL_LIMIT) begin
                    $display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
                    $display("tb_top NOT OK");
                    $finish;
                end
            end
        end
    end

    task automatic send_colour(input logic [15:0] hue, input logic [6:0] sat,
                               input logic [6:0] light);
        while (!no_idle && $urandom_range(99) < 22) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {2'b00, light, sat, hue};
        do @(posedge aclk); while (!s_tready);
    endtask

    function automatic logic [6:0] pick_pct();
        if ($urandom_range(99) < 80)
            return 7'($urandom_range(100));
        return 7'($urandom_range(127));
    endfunction

    function automatic logic [15:0] pick_hue();
        int sel;
        sel = $urandom_range(99);
        if (sel < 50)
            return 16'($urandom_range(359));
        if (sel < 80)
            return 16'($urandom());
        // sector edge, possibly in a later turn of the wheel
        return 16'($urandom_range(1, 6) * 60 - $urandom_range(1) + 360 * $urandom_range(180));
    endfunction

    initial begin
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send_colour(16'd0,     7'd100, 7'd50);
        send_colour(16'd59,    7'd100, 7'd50);
        send_colour(16'd60,    7'd100, 7'd50);
        send_colour(16'd119,   7'd100, 7'd50);
        send_colour(16'd120,   7'd100, 7'd50);
        send_colour(16'd179,   7'd100, 7'd50);
        send_colour(16'd180,   7'd100, 7'd50);
        send_colour(16'd239,   7'd100, 7'd50);
        send_colour(16'd240,   7'd100, 7'd50);
        send_colour(16'd299,   7'd100, 7'd50);
        send_colour(16'd300,   7'd100, 7'd50);
        send_colour(16'd359,   7'd100, 7'd50);
        send_colour(16'd360,   7'd100, 7'd50);
        send_colour(16'd719,   7'd80,  7'd30);
        send_colour(16'hFFFF,  7'd100, 7'd50);
        send_colour(16'd200,   7'd0,   7'd0);
        send_colour(16'd200,   7'd0,   7'd100);
        send_colour(16'd200,   7'd100, 7'd100);
        send_colour(16'd200,   7'd100, 7'd0);
        send_colour(16'd45,    7'd127, 7'd50);
        send_colour(16'd45,    7'd101, 7'd127);
        send_colour(16'd45,    7'd60,  7'd101);
        send_colour(16'd45,    7'd127, 7'd127);
        send_colour(16'd330,   7'd1,   7'd99);

        for (int i = 0; i < RANDOM_COLOURS; i++) begin
            no_idle = (i >= 700 && i < 1000);
            send_colour(pick_hue(), pick_pct(), pick_pct());
        end
        no_idle = 1'b0;
        s_tvalid <= 1'b0;

        while (pixel_sb.pending_pixels.size() != 0)
            @(posedge aclk);
        repeat (12) @(posedge aclk);

        if (pixel_sb.fail_count == 0) begin
            $display("tb_top OK");
        end else begin
            $display("tb_top NOT OK");
        end
        $finish;
    end

endmodule
